// ----- rtl/core/tewc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewc_pkg
// Shared types and constants of the timing window check on reference and data edges.
// ----------------------------------------------------------------------------
package tewc_pkg;

  localparam int TIME_BITS = 63;
  localparam int LIMIT_W   = 32;
  localparam int CMP_W     = (TIME_BITS + 2 > LIMIT_W + 2) ? TIME_BITS + 2 : LIMIT_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_SETUPHOLD = 2'd0,
    KIND_REMOVAL   = 2'd1,
    KIND_RECOVERY  = 2'd2,
    KIND_RECREM    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SIDE_NONE   = 2'd0,
    SIDE_BEFORE = 2'd1,
    SIDE_AFTER  = 2'd2
  } side_e;

  typedef enum logic {
    ACT_REF  = 1'b0,
    ACT_DATA = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_KIND          = 3'd0,
    CFG_FIRST_LIMIT         = 3'd1,
    CFG_SECOND_LIMIT        = 3'd2,
    CFG_FIRST_SIGNED_LIMIT  = 3'd3,
    CFG_SECOND_SIGNED_LIMIT = 3'd4,
    CFG_NEGATIVE_LIMITS_ON  = 3'd5,
    CFG_CHECKS_OFF          = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    kind_e                     check_kind;
    logic [LIMIT_W-1:0]        first_limit;
    logic [LIMIT_W-1:0]        second_limit;
    logic signed [LIMIT_W-1:0] first_signed_limit;
    logic signed [LIMIT_W-1:0] second_signed_limit;
    logic                      negative_limits_on;
    logic                      checks_off;
  } cfg_t;

  typedef struct packed {
    logic                 ref_seen;
    logic [TIME_BITS-1:0] ref_time;
    logic                 data_seen;
    logic [TIME_BITS-1:0] data_time;
  } edge_state_t;

endpackage

// ----- rtl/core/tewc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewc interfaces
// Valid/ready channels for edge events, check results and register writes.
// ----------------------------------------------------------------------------
interface tewc_evt_if import tewc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [TIME_BITS-1:0] event_time;

  modport source (output valid, action, event_time, input ready);
  modport sink   (input valid, action, event_time, output ready);
endinterface

interface tewc_res_if import tewc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] violation_side;
  logic       notifier_level;

  modport source (output valid, violation_side, notifier_level, input ready);
  modport sink   (input valid, violation_side, notifier_level, output ready);
endinterface

interface tewc_cfg_if import tewc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tewc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewc_cfg_regs
// Configuration register file, one write word per cycle.
// ----------------------------------------------------------------------------
module tewc_cfg_regs import tewc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tewc_cfg_if.sink     cfg_i,
  output cfg_t         cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CHECK_KIND:          cfg_q.check_kind <= kind_e'(cfg_i.data[1:0]);
        CFG_FIRST_LIMIT:         cfg_q.first_limit <= cfg_i.data[LIMIT_W-1:0];
        CFG_SECOND_LIMIT:        cfg_q.second_limit <= cfg_i.data[LIMIT_W-1:0];
        CFG_FIRST_SIGNED_LIMIT:  cfg_q.first_signed_limit <= cfg_i.data[LIMIT_W-1:0];
        CFG_SECOND_SIGNED_LIMIT: cfg_q.second_signed_limit <= cfg_i.data[LIMIT_W-1:0];
        CFG_NEGATIVE_LIMITS_ON:  cfg_q.negative_limits_on <= cfg_i.data[0];
        CFG_CHECKS_OFF:          cfg_q.checks_off <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/tewc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewc_in_stage
// Input register for edge events with valid/ready flow control.
// ----------------------------------------------------------------------------
module tewc_in_stage import tewc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tewc_evt_if.sink             evt_i,
  input  logic                 adv_i,
  output logic                 valid_o,
  output logic                 action_o,
  output logic [TIME_BITS-1:0] time_o
);

  logic                 valid_q;
  logic                 action_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 take;

  assign evt_i.ready = !valid_q || adv_i;
  assign take        = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= evt_i.action;
      time_q   <= evt_i.event_time;
    end
  end

  assign valid_o  = valid_q;
  assign action_o = action_q;
  assign time_o   = time_q;

endmodule

// ----- rtl/core/tewc_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewc_eval
// Edge state update and window evaluation for one event.
// ----------------------------------------------------------------------------
module tewc_eval import tewc_pkg::*; (
  input  cfg_t                 cfg_i,
  input  logic                 action_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  edge_state_t          state_i,
  output edge_state_t          state_o,
  output side_e                side_o
);

  logic                    is_data;
  logic                    closes;
  logic                    both_seen;
  logic signed [CMP_W-1:0] ref_ext;
  logic signed [CMP_W-1:0] dat_ext;
  logic signed [CMP_W-1:0] gap;
  logic signed [CMP_W-1:0] first_u;
  logic signed [CMP_W-1:0] second_u;
  logic signed [CMP_W-1:0] first_s;
  logic signed [CMP_W-1:0] second_s;
  logic signed [CMP_W-1:0] lim_before;
  logic signed [CMP_W-1:0] lim_after;
  logic signed [CMP_W-1:0] sum_before;
  logic signed [CMP_W-1:0] sum_first;
  logic                    gap_neg;
  logic                    gap_le;
  logic                    hit;

  assign is_data = (action_e'(action_i) == ACT_DATA);

  always_comb begin
    state_o = state_i;
    if (is_data) begin
      state_o.data_seen = 1'b1;
      state_o.data_time = time_i;
    end else begin
      state_o.ref_seen = 1'b1;
      state_o.ref_time = time_i;
    end
  end

  // data minus reference, exact in the wide signed domain
  assign ref_ext  = signed'({{(CMP_W-TIME_BITS){1'b0}}, state_o.ref_time});
  assign dat_ext  = signed'({{(CMP_W-TIME_BITS){1'b0}}, state_o.data_time});
  assign gap      = dat_ext - ref_ext;
  assign gap_neg  = gap[CMP_W-1];
  assign gap_le   = gap_neg || (gap == '0);

  assign first_u  = signed'({{(CMP_W-LIMIT_W){1'b0}}, cfg_i.first_limit});
  assign second_u = signed'({{(CMP_W-LIMIT_W){1'b0}}, cfg_i.second_limit});
  assign first_s  = signed'({{(CMP_W-LIMIT_W){cfg_i.first_signed_limit[LIMIT_W-1]}},
                             cfg_i.first_signed_limit});
  assign second_s = signed'({{(CMP_W-LIMIT_W){cfg_i.second_signed_limit[LIMIT_W-1]}},
                             cfg_i.second_signed_limit});

  always_comb begin
    priority if (cfg_i.negative_limits_on && cfg_i.check_kind == KIND_RECREM) begin
      lim_before = second_s;
      lim_after  = first_s;
    end else if (cfg_i.negative_limits_on) begin
      lim_before = first_s;
      lim_after  = second_s;
    end else if (cfg_i.check_kind == KIND_RECREM) begin
      lim_before = second_u;
      lim_after  = first_u;
    end else begin
      lim_before = first_u;
      lim_after  = second_u;
    end
  end

  assign sum_before = gap + lim_before;
  assign sum_first  = gap + first_u;
  assign both_seen  = state_o.ref_seen && state_o.data_seen;

  always_comb begin
    closes = 1'b0;
    hit    = 1'b0;
    side_o = SIDE_NONE;
    unique case (cfg_i.check_kind)
      KIND_REMOVAL: begin
        closes = !is_data;
        hit    = gap_neg && !sum_first[CMP_W-1] && (sum_first != '0);
        side_o = (both_seen && closes && hit) ? SIDE_BEFORE : SIDE_NONE;
      end
      KIND_RECOVERY: begin
        closes = is_data;
        hit    = !gap_neg && (gap < first_u);
        side_o = (both_seen && closes && hit) ? SIDE_AFTER : SIDE_NONE;
      end
      default: begin
        closes = 1'b1;
        if (cfg_i.checks_off) begin
          hit = 1'b0;
        end else if (cfg_i.negative_limits_on) begin
          hit = !sum_before[CMP_W-1] && (sum_before != '0) && (gap < lim_after);
        end else if (gap_le) begin
          hit = !sum_before[CMP_W-1] && (sum_before != '0);
        end else begin
          hit = (gap < lim_after);
        end
        if (both_seen && closes && hit) begin
          side_o = gap_le ? SIDE_BEFORE : SIDE_AFTER;
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/two_edge_timing_window_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_edge_timing_window_check_top
// Setuphold / removal / recovery / recrem window check on timestamped edges.
//
//   channel  dir  modport         word
//   evt_i    in   tewc_evt_if     action, event_time
//   res_o    out  tewc_res_if     violation_side, notifier_level
//   cfg_i    in   tewc_cfg_if     index, data (register write)
//
// One event per cycle unless a held result stalls. An accepted event passes
// the input register, then the window compare into the result register.
// The subtract and compares on the stored edge times set the cycle.
// A held result stalls only the input register; one more event is taken.
// Reset clears edge state, notifier and all configuration registers.
// ----------------------------------------------------------------------------
module two_edge_timing_window_check_top import tewc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tewc_evt_if.sink   evt_i,
  tewc_res_if.source res_o,
  tewc_cfg_if.sink   cfg_i
);

  cfg_t                 cfg;
  logic                 s1_valid;
  logic                 s1_action;
  logic [TIME_BITS-1:0] s1_time;
  logic                 adv;
  edge_state_t          state_q;
  edge_state_t          state_d;
  side_e                side_d;
  logic                 notifier_q;
  logic                 notifier_d;
  logic                 res_valid_q;
  side_e                res_side_q;
  logic                 res_notifier_q;

  tewc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tewc_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt_i),
    .adv_i    (adv),
    .valid_o  (s1_valid),
    .action_o (s1_action),
    .time_o   (s1_time)
  );

  tewc_eval u_eval (
    .cfg_i    (cfg),
    .action_i (s1_action),
    .time_i   (s1_time),
    .state_i  (state_q),
    .state_o  (state_d),
    .side_o   (side_d)
  );

  assign adv        = s1_valid && (!res_valid_q || res_o.ready);
  assign notifier_d = notifier_q ^ (side_d != SIDE_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      notifier_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q     <= state_d;
        notifier_q  <= notifier_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_side_q     <= side_d;
      res_notifier_q <= notifier_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.violation_side = res_side_q;
  assign res_o.notifier_level = res_notifier_q;

`ifndef SYNTH
  a_notifier_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (res_notifier_q == notifier_q))
    else $error("result notifier differs from notifier state");

  a_toggle_on_violation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> ((notifier_q != $past(notifier_q)) == (res_side_q != SIDE_NONE)))
    else $error("notifier toggle does not match violation");

  a_unseen_no_violation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !(state_d.ref_seen && state_d.data_seen)) |=> (res_side_q == SIDE_NONE))
    else $error("violation before both edges seen");

  a_removal_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cfg.check_kind == KIND_REMOVAL) |=> (res_side_q != SIDE_AFTER))
    else $error("removal reported after side");

  a_recovery_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cfg.check_kind == KIND_RECOVERY) |=> (res_side_q != SIDE_BEFORE))
    else $error("recovery reported before side");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_i.ready |-> (s1_valid && res_valid_q))
    else $error("input stalled with room available");
`endif

endmodule

// ----- test/tb_two_edge_timing_window_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_edge_timing_window_check_top
// Drives timestamped reference and data edges into the window check under a
// series of register settings. A scoreboard mirrors the edge state, the
// notifier and the registers, works out the violation side and notifier
// level for every accepted edge, and compares each result word in order.
// Both sides idle at random, in three phases of different pressure; the last has no idling.
// ----------------------------------------------------------------------------
module tb_two_edge_timing_window_check_top;
  import tewc_pkg::*;

  typedef struct packed {
    side_e side;
    logic  notifier;
  } outcome_t;

  class edge_window_tracker;
    cfg_t        regs;
    edge_state_t edges;
    logic        notifier;
    outcome_t    pending[$];
    int          errors;

    function new();
      regs     = '0;
      edges    = '0;
      notifier = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CHECK_KIND:          regs.check_kind = kind_e'(val[1:0]);
        CFG_FIRST_LIMIT:         regs.first_limit = val;
        CFG_SECOND_LIMIT:        regs.second_limit = val;
        CFG_FIRST_SIGNED_LIMIT:  regs.first_signed_limit = val;
        CFG_SECOND_SIGNED_LIMIT: regs.second_signed_limit = val;
        CFG_NEGATIVE_LIMITS_ON:  regs.negative_limits_on = val[0];
        CFG_CHECKS_OFF:          regs.checks_off = val[0];
        default: ;
      endcase
    endfunction

    function side_e two_sided_side();
      logic [LIMIT_W-1:0]          lim_b, lim_a;
      logic signed [LIMIT_W-1:0]   slim_b, slim_a;
      logic signed [TIME_BITS+1:0] gap, lo, hi;
      logic [TIME_BITS-1:0]        r, d;
      logic                        hit;
      r = edges.ref_time;
      d = edges.data_time;
      if (regs.checks_off) return SIDE_NONE;
      if (regs.check_kind == KIND_RECREM) begin
        lim_b  = regs.second_limit;
        lim_a  = regs.first_limit;
        slim_b = regs.second_signed_limit;
        slim_a = regs.first_signed_limit;
      end else begin
        lim_b  = regs.first_limit;
        lim_a  = regs.second_limit;
        slim_b = regs.first_signed_limit;
        slim_a = regs.second_signed_limit;
      end
      if (regs.negative_limits_on) begin
        gap = $signed({2'b00, d}) - $signed({2'b00, r});
        lo  = slim_b;
        lo  = -lo;
        hi  = slim_a;
        hit = (gap > lo) && (gap < hi);
      end else if (lim_b == '0 && lim_a == '0) begin
        hit = 1'b0;
      end else if (d <= r) begin
        hit = (r - d) < lim_b;
      end else begin
        hit = (d - r) < lim_a;
      end
      if (!hit) return SIDE_NONE;
      return (d <= r) ? SIDE_BEFORE : SIDE_AFTER;
    endfunction

    function void note_edge(action_e act, logic [TIME_BITS-1:0] t);
      logic                 closes;
      side_e                side;
      logic [TIME_BITS-1:0] r, d;
      side = SIDE_NONE;
      if (act == ACT_DATA) begin
        edges.data_seen = 1'b1;
        edges.data_time = t;
      end else begin
        edges.ref_seen = 1'b1;
        edges.ref_time = t;
      end
      case (regs.check_kind)
        KIND_REMOVAL:  closes = (act == ACT_REF);
        KIND_RECOVERY: closes = (act == ACT_DATA);
        default:       closes = 1'b1;
      endcase
      r = edges.ref_time;
      d = edges.data_time;
      if (edges.ref_seen && edges.data_seen && closes) begin
        case (regs.check_kind)
          KIND_REMOVAL: begin
            if (d < r && (r - d) < regs.first_limit) side = SIDE_BEFORE;
          end
          KIND_RECOVERY: begin
            if (d >= r && (d - r) < regs.first_limit) side = SIDE_AFTER;
          end
          default: side = two_sided_side();
        endcase
      end
      if (side != SIDE_NONE) notifier = ~notifier;
      pending.push_back('{side, notifier});
    endfunction

    function void check_outcome(logic [1:0] side, logic notif);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with none pending: side=%0d notifier=%0d",
                   $realtime, side, notif);
        return;
      end
      want = pending.pop_front();
      if (side !== want.side || notif !== want.notifier) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: side exp=%0d act=%0d, notifier exp=%0d act=%0d",
                   $realtime, want.side, side, want.notifier, notif);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;

  logic [TIME_BITS-1:0] anchor;
  longint               scale;

  edge_window_tracker tracker = new();

  tewc_evt_if evt ();
  tewc_res_if res ();
  tewc_cfg_if cfg ();

  two_edge_timing_window_check_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(2_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // result receiver with random back-pressure
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready)
      tracker.check_outcome(res.violation_side, res.notifier_level);
  end

  task automatic send_edge(action_e act, logic [TIME_BITS-1:0] t);
    evt.valid      <= 1'b1;
    evt.action     <= act;
    evt.event_time <= t;
    do @(posedge clk); while (!evt.ready);
    tracker.note_edge(act, t);
    if ($urandom_range(99) < send_idle) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // wait until every result word is back, then let the pipe go quiet
  task automatic settle();
    evt.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    tracker.write_reg(idx, val);
  endtask

  task automatic apply_setup(kind_e k, logic [31:0] f, logic [31:0] s, logic [31:0] fs,
                             logic [31:0] ss, logic neg, logic off);
    settle();
    cfg_write(CFG_CHECK_KIND, {30'd0, k});
    cfg_write(CFG_FIRST_LIMIT, f);
    cfg_write(CFG_SECOND_LIMIT, s);
    cfg_write(CFG_FIRST_SIGNED_LIMIT, fs);
    cfg_write(CFG_SECOND_SIGNED_LIMIT, ss);
    cfg_write(CFG_NEGATIVE_LIMITS_ON, {31'd0, neg});
    cfg_write(CFG_CHECKS_OFF, {31'd0, off});
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_signed_limit();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function automatic longint magnitude(logic [31:0] v, logic is_signed);
    longint x;
    x = is_signed ? longint'($signed(v)) : longint'({32'd0, v});
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint window_scale(logic [31:0] f, logic [31:0] s, logic [31:0] fs,
                                          logic [31:0] ss, logic neg);
    longint a, b;
    a = neg ? magnitude(fs, 1'b1) : magnitude(f, 1'b0);
    b = neg ? magnitude(ss, 1'b1) : magnitude(s, 1'b0);
    if (b > a) a = b;
    return (a < 4) ? 4 : a;
  endfunction

  // edge times cluster around an anchor so the windows are straddled
  function automatic logic [TIME_BITS-1:0] next_time();
    logic [63:0] rnd;
    longint      span, off;
    if ($urandom_range(15) == 0) anchor = TIME_BITS'({$urandom, $urandom});
    rnd = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return rnd[TIME_BITS-1:0];
    span = 4 * scale + 1;
    off  = longint'(rnd % span) - 2 * scale;
    return anchor + off[TIME_BITS-1:0];
  endfunction

  initial begin
    int                   seg, i;
    logic [31:0]          f, s, fs, ss;
    logic                 neg, off;
    kind_e                k;
    logic [TIME_BITS-1:0] tmax;

    tmax = '1;
    rst_n          <= 1'b0;
    evt.valid      <= 1'b0;
    evt.action     <= ACT_REF;
    evt.event_time <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_CHECK_KIND;
    cfg.data       <= '0;
    send_idle = 18;
    recv_idle = 61;
    anchor    = '0;
    scale     = 4;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: both limits zero, nothing can violate
    send_edge(ACT_REF, '0);
    send_edge(ACT_DATA, '0);

    apply_setup(KIND_SETUPHOLD, 10, 5, 0, 0, 1'b0, 1'b0);
    send_edge(ACT_REF, 100);
    send_edge(ACT_DATA, 95);
    send_edge(ACT_DATA, 100);
    send_edge(ACT_DATA, 104);
    send_edge(ACT_DATA, 105);
    send_edge(ACT_REF, tmax);
    send_edge(ACT_DATA, tmax);

    // recrem swaps the limit roles
    apply_setup(KIND_RECREM, 10, 5, 0, 0, 1'b0, 1'b0);
    send_edge(ACT_REF, 1000);
    send_edge(ACT_DATA, 996);
    send_edge(ACT_DATA, 1008);

    apply_setup(KIND_REMOVAL, 10, 0, 0, 0, 1'b0, 1'b0);
    send_edge(ACT_DATA, 50);
    send_edge(ACT_REF, 55);
    send_edge(ACT_DATA, 56);
    send_edge(ACT_REF, 56);

    apply_setup(KIND_RECOVERY, 10, 0, 0, 0, 1'b0, 1'b0);
    send_edge(ACT_REF, 200);
    send_edge(ACT_DATA, 205);
    send_edge(ACT_REF, 210);
    send_edge(ACT_DATA, 209);

    // open signed window strictly after the reference edge
    apply_setup(KIND_SETUPHOLD, 0, 0, -3, 8, 1'b1, 1'b0);
    send_edge(ACT_REF, 300);
    send_edge(ACT_DATA, 305);
    send_edge(ACT_DATA, 302);

    // same window, checks switched off
    apply_setup(KIND_RECREM, 0, 0, 8, -3, 1'b1, 1'b1);
    send_edge(ACT_DATA, 305);

    for (seg = 0; seg < 12; seg++) begin
      if (seg < 4) begin
        send_idle = 18;
        recv_idle = 61;
      end else if (seg < 8) begin
        send_idle = 61;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      k   = kind_e'($urandom_range(3));
      f   = pick_limit();
      s   = pick_limit();
      fs  = pick_signed_limit();
      ss  = pick_signed_limit();
      neg = $urandom_range(1);
      off = ($urandom_range(4) == 0);
      case (seg)
        0: begin
          k = KIND_SETUPHOLD; f = '1; s = '1; neg = 1'b0; off = 1'b0;
        end
        1: begin
          k = KIND_RECREM; f = '0; s = '0; neg = 1'b0; off = 1'b0;
        end
        2: begin
          k = KIND_SETUPHOLD; fs = 32'h7FFF_FFFF; ss = 32'h7FFF_FFFF; neg = 1'b1; off = 1'b0;
        end
        3: begin
          k = KIND_RECREM; fs = 32'h8000_0000; ss = 32'h8000_0000; neg = 1'b1; off = 1'b0;
        end
        default: ;
      endcase
      case ($urandom_range(3))
        0:       anchor = '0;
        1:       anchor = tmax - $urandom_range(0, 1000);
        default: anchor = TIME_BITS'({$urandom, $urandom});
      endcase
      scale = window_scale(f, s, fs, ss, neg);
      apply_setup(k, f, s, fs, ss, neg, off);
      for (i = 0; i < 77; i++)
        send_edge(action_e'($urandom_range(1)), next_time());
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- two_edge_timing_window_check_top.f -----
rtl/core/tewc_pkg.sv
rtl/core/tewc_if.sv
rtl/core/tewc_cfg_regs.sv
rtl/core/tewc_in_stage.sv
rtl/core/tewc_eval.sv
rtl/core/two_edge_timing_window_check_top.sv
test/tb_two_edge_timing_window_check_top.sv
